FILE: src/assert_macros.svh
// Assertion macros shared by the sorted array engine RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define SAE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true on a rising clock edge outside reset.
`define SAE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/sae_pkg.sv
// Shared types and constants for the sorted array engine.
// No dependencies; imported by the controller, datapath and top level.
package sae_pkg;

	localparam int CW = 7;   // entry count and capacity width
	localparam int VW = 32;  // entry value width
	localparam int PW = 6;   // table index width

	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_WALK,
		ST_REM_WALK,
		ST_LOOK_WAIT,
		ST_FINISH
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;   // latch the incoming beat
		logic ins_start; // begin the downward insert walk
		logic rem_start; // begin the upward remove walk
		logic look_rd;   // read the entry at the lookup index
		logic look_cap;  // take the lookup read data as result
		logic ins_put;   // store the new value at its slot
		logic rem_end;   // close the remove, drop the count
		logic res_fail;  // result is a failure
		logic out_load;  // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		op_t  op;
		logic full;
		logic pos_ok;
		logic busy;
	} dp_stat_t;

endpackage

FILE: src/sae_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/sae_ctrl.sv
// Controller state machine of the sorted array engine.
// Depends on sae_pkg and assert_macros.svh; drives the datapath commands.
module sae_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	output logic              m_valid,
	input  logic              m_ready,
	input  sae_pkg::dp_stat_t stat,
	output sae_pkg::dp_cmd_t  cmd
);
	import sae_pkg::*;

	`include "assert_macros.svh"

	state_t state_q, state_d;
	logic   m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (stat.op)
					OP_INSERT: state_d = stat.full ? ST_FINISH : ST_INS_WALK;
					OP_LOOKUP: state_d = stat.pos_ok ? ST_LOOK_WAIT : ST_FINISH;
					OP_REMOVE: state_d = stat.pos_ok ? ST_REM_WALK : ST_FINISH;
					default:   state_d = ST_FINISH;
				endcase
			end
			ST_INS_WALK: begin
				if (!stat.busy) state_d = ST_FINISH;
			end
			ST_REM_WALK: begin
				if (!stat.busy) state_d = ST_FINISH;
			end
			ST_LOOK_WAIT: state_d = ST_FINISH;
			ST_FINISH: begin
				if (!m_valid_q || m_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		s_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_ready     = 1'b1;
				cmd.capture = s_valid;
			end
			ST_DISPATCH: begin
				case (stat.op)
					OP_INSERT: begin
						cmd.res_fail  = stat.full;
						cmd.ins_start = !stat.full;
					end
					OP_LOOKUP: begin
						cmd.res_fail = !stat.pos_ok;
						cmd.look_rd  = stat.pos_ok;
					end
					OP_REMOVE: begin
						cmd.res_fail  = !stat.pos_ok;
						cmd.rem_start = stat.pos_ok;
					end
					default: cmd.res_fail = 1'b1;
				endcase
			end
			ST_INS_WALK:  cmd.ins_put  = !stat.busy;
			ST_REM_WALK:  cmd.rem_end  = !stat.busy;
			ST_LOOK_WAIT: cmd.look_cap = 1'b1;
			ST_FINISH:    cmd.out_load = !m_valid_q || m_ready;
			default: ;
		endcase
	end

	assign m_valid = m_valid_q;

	`SAE_ASSERT(a_accept_dispatch, clk, arst_n, (s_valid && s_ready) |=> (state_q == ST_DISPATCH), "accepted beat not dispatched")
	`SAE_ASSERT(a_finish_result, clk, arst_n, (state_q == ST_FINISH && (!m_valid_q || m_ready)) |=> (m_valid_q && state_q == ST_IDLE), "finished item left no result")
	`SAE_ASSERT(a_lookup_order, clk, arst_n, (state_q == ST_LOOK_WAIT) |-> ($past(state_q) == ST_DISPATCH), "lookup wait without dispatch")

endmodule

FILE: src/sae_dp.sv
// Datapath of the sorted array engine: entry RAM, count, walk pointers, result.
// Depends on sae_pkg, sae_ram and assert_macros.svh.
module sae_dp #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [sae_pkg::CW-1:0]    cfg_wr_data,
	input  sae_pkg::op_t              in_op,
	input  logic [sae_pkg::VW-1:0]    in_value,
	input  logic [sae_pkg::PW-1:0]    in_pos,
	input  sae_pkg::dp_cmd_t          cmd,
	output sae_pkg::dp_stat_t         stat,
	output logic                      out_ok,
	output logic [sae_pkg::VW-1:0]    out_value,
	output logic [sae_pkg::CW-1:0]    out_count
);
	import sae_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = $clog2(DEPTH);

	op_t           op_q;
	logic [VW-1:0] val_q;
	logic [PW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cap_q;
	logic [CW-1:0] ptr_q;
	logic          iss_q;
	logic          rv_s1;
	logic [CW-1:0] addr_s1;
	logic [CW-1:0] slot_q;
	logic          res_ok_q;
	logic [VW-1:0] res_val_q;
	logic          out_ok_q;
	logic [VW-1:0] out_val_q;
	logic [CW-1:0] out_cnt_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;

	logic          ins_walk;
	logic          ge;
	logic          ins_stop;
	logic [CW-1:0] pos_ext;
	logic [CW-1:0] ptr_inc;

	assign pos_ext  = CW'(pos_q);
	assign ptr_inc  = ptr_q + CNT_ONE;
	assign ins_walk = (op_q == OP_INSERT);
	assign ge       = (ram_rdata >= val_q);
	assign ins_stop = rv_s1 && ins_walk && (!ge || addr_s1 == '0);

	assign stat.op     = op_q;
	assign stat.full   = (cnt_q >= cap_q) || (32'(cnt_q) >= 32'(DEPTH));
	assign stat.pos_ok = (pos_ext < cnt_q);
	assign stat.busy   = iss_q | rv_s1;

	// Read port: lookup index or the walk pointer.
	assign ram_re    = cmd.look_rd | iss_q;
	assign ram_raddr = cmd.look_rd ? AW'(pos_q) : AW'(ptr_q);

	// Write port: final insert store, or one shifted entry per cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(slot_q);
		ram_wdata = val_q;
		if (cmd.ins_put) begin
			ram_we = 1'b1;
		end else if (rv_s1) begin
			ram_wdata = ram_rdata;
			if (ins_walk) begin
				ram_we    = ge;
				ram_waddr = AW'(addr_s1 + CNT_ONE);
			end else begin
				ram_we    = 1'b1;
				ram_waddr = AW'(addr_s1 - CNT_ONE);
			end
		end
	end

	sae_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_NONE;
			cnt_q  <= '0;
			cap_q  <= CW'(64);
			ptr_q  <= '0;
			iss_q  <= 1'b0;
			rv_s1  <= 1'b0;
			slot_q <= '0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (cmd.capture) op_q <= in_op;

			rv_s1 <= iss_q & ~ins_stop;

			if (cmd.ins_start) begin
				ptr_q  <= cnt_q - CNT_ONE;
				iss_q  <= (cnt_q != '0);
				slot_q <= '0;
			end else if (cmd.rem_start) begin
				ptr_q <= pos_ext + CNT_ONE;
				iss_q <= ((pos_ext + CNT_ONE) < cnt_q);
			end else if (ins_stop) begin
				iss_q  <= 1'b0;
				slot_q <= ge ? '0 : addr_s1 + CNT_ONE;
			end else if (iss_q) begin
				if (ins_walk) begin
					if (ptr_q == '0) iss_q <= 1'b0;
					else ptr_q <= ptr_q - CNT_ONE;
				end else begin
					ptr_q <= ptr_inc;
					iss_q <= (ptr_inc < cnt_q);
				end
			end

			if (cmd.ins_put) cnt_q <= cnt_q + CNT_ONE;
			else if (cmd.rem_end) cnt_q <= cnt_q - CNT_ONE;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		if (cmd.capture) begin
			val_q <= in_value;
			pos_q <= in_pos;
		end
		if (cmd.res_fail) begin
			res_ok_q  <= 1'b0;
			res_val_q <= '0;
		end else if (cmd.ins_put || cmd.rem_end) begin
			res_ok_q  <= 1'b1;
			res_val_q <= '0;
		end else if (cmd.look_cap) begin
			res_ok_q  <= 1'b1;
			res_val_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			out_ok_q  <= res_ok_q;
			out_val_q <= res_val_q;
			out_cnt_q <= cnt_q;
		end
	end

	assign out_ok    = out_ok_q;
	assign out_value = out_val_q;
	assign out_count = out_cnt_q;

	`SAE_ASSERT(a_count_bound, clk, arst_n, 32'(cnt_q) <= 32'(DEPTH), "entry count above depth")
	`SAE_ASSERT_NEVER(a_put_during_walk, clk, arst_n, cmd.ins_put && (iss_q || rv_s1), "insert store collides with walk")
	`SAE_ASSERT(a_count_step, clk, arst_n, (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_ONE || cnt_q == $past(cnt_q) - CNT_ONE), "entry count jumped")

endmodule

FILE: src/sorted_array_engine_top.sv
// Sorted array engine: ordered table of unsigned 32-bit entries in one RAM, one command at a time.
// A failed command goes straight to the result; a lookup reads one entry; a remove or an
// insert walks the table, moving one entry per RAM cycle.
// The result beat becomes valid in the same cycle that s_axis_tready rises for the next command beat.
// Reset (arst_n, async, active low) clears count and state, capacity goes to 64; RAM is kept.
module sorted_array_engine_top #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Capacity register write
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	// Command stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] item_value, [37:32] position, [39:38] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] read_value, [38:32] entry_count, [39] zero
	output logic [0:0]  m_axis_tuser   // [0] ok
);
	import sae_pkg::*;

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic          out_ok;
	logic [VW-1:0] out_value;
	logic [CW-1:0] out_count;

	// Sequencer: accept, dispatch, walk the table, stage the result beat.
	sae_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Table storage, count, walk pointers and the output register.
	sae_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_op       (op_t'(s_axis_tuser)),
		.in_value    (s_axis_tdata[31:0]),
		.in_pos      (s_axis_tdata[37:32]),
		.cmd         (cmd),
		.stat        (stat),
		.out_ok      (out_ok),
		.out_value   (out_value),
		.out_count   (out_count)
	);

	// Pack the result beat, low field first, pad to whole bytes.
	assign m_axis_tdata = {1'b0, out_count, out_value};
	assign m_axis_tuser = out_ok;

endmodule

FILE: bench/sae_check_pkg.sv
`timescale 1ns / 1ps
// Result tracking for the sorted array engine bench: a software copy of the ordered
// table and the queue of results still owed by the block. Depends on sae_pkg.
package sae_check_pkg;
	import sae_pkg::*;

	localparam int TABLE_DEPTH = 64;

	typedef struct packed {
		bit          ok;
		bit [VW-1:0] read_value;
		bit [CW-1:0] entry_count;
	} table_result_t;

	class ordered_table_tracker;
		bit [VW-1:0]   entries[$];
		bit [CW-1:0]   capacity;
		table_result_t awaited[$];
		int            mismatches;
		int            results_seen;

		function new();
			capacity = CW'(64);
			mismatches = 0;
			results_seen = 0;
		endfunction

		// Apply one accepted command beat to the table and queue the result it owes.
		function void apply_command(op_t op, bit [VW-1:0] value, bit [PW-1:0] pos);
			table_result_t r;
			int slot;
			int room;
			r = '0;
			room = (capacity < TABLE_DEPTH) ? int'(capacity) : TABLE_DEPTH;
			case (op)
				OP_INSERT: begin
					if (entries.size() < room) begin
						slot = 0;
						while (slot < entries.size() && entries[slot] < value)
							slot++;
						entries.insert(slot, value);
						r.ok = 1'b1;
					end
				end
				OP_LOOKUP: begin
					if (pos < entries.size()) begin
						r.ok = 1'b1;
						r.read_value = entries[pos];
					end
				end
				OP_REMOVE: begin
					if (pos < entries.size()) begin
						entries.delete(pos);
						r.ok = 1'b1;
					end
				end
				default: begin
				end
			endcase
			r.entry_count = CW'(entries.size());
			awaited.push_back(r);
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// Compare one accepted result beat with the oldest owed result.
		function void check_result(logic ok, logic [VW-1:0] value, logic [CW-1:0] count);
			table_result_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				note_mismatch($sformatf("result %0d with nothing pending: ok=%0b value=%h count=%0d",
					results_seen, ok, value, count));
				return;
			end
			want = awaited.pop_front();
			if (ok !== want.ok || value !== want.read_value || count !== want.entry_count)
				note_mismatch($sformatf(
					"result %0d expected ok=%0b value=%h count=%0d, got ok=%0b value=%h count=%0d",
					results_seen, want.ok, want.read_value, want.entry_count, ok, value, count));
		endfunction
	endclass

endpackage

FILE: bench/sorted_array_engine_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_array_engine_top: directed and random command beats
// under several flow-control mixes and capacity settings. Depends on sae_pkg, sae_check_pkg.
module sorted_array_engine_top_tb;
	import sae_pkg::*;
	import sae_check_pkg::*;

	// Longest quiet stretch tolerated: far longer than a full-table shift, so
	// this leaves a wide margin for stalls on the result side.
	localparam int STALL_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [6:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [31:0] item_value, [37:32] position, [39:38] zero
	logic [1:0]  s_axis_tuser;   // [1:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;   // [31:0] read_value, [38:32] entry_count, [39] zero
	logic [0:0]  m_axis_tuser;   // [0] ok

	ordered_table_tracker tracker;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int quiet_cycles = 0;

	sorted_array_engine_top #(
		.DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: check every accepted beat, then pick tready for the next edge.
	// The watchdog shares this block so it sees both handshakes on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_result(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[38:32]);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Present one command beat and hold it until accepted. Random idle cycles
	// come first; tvalid is never dropped on the edge that accepted the last beat
	// unless this beat idles, so back-to-back beats keep it high.
	task automatic send_command(input op_t op, input logic [VW-1:0] value,
			input logic [PW-1:0] pos);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata  <= {2'b00, pos, value};
		s_axis_tuser  <= op;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.apply_command(op, value, pos);
	endtask

	// Drop tvalid and hold off until every owed result has come back, then let
	// the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the capacity register while the block is idle.
	task automatic set_capacity(input logic [CW-1:0] cap);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.capacity = cap;
		@(posedge clk);
	endtask

	// One random phase: capacity, flow-control mix, beat count and insert share.
	// Most positions land inside the table so removes and lookups mostly succeed.
	task automatic run_phase(input logic [CW-1:0] cap, input int sender_pct,
			input int receiver_pct, input int beats, input int insert_pct);
		int i;
		int roll;
		int fill;
		op_t op;
		logic [VW-1:0] value;
		logic [PW-1:0] pos;
		set_capacity(cap);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
		for (i = 0; i < beats; i++) begin
			fill = tracker.entries.size();
			roll = $urandom_range(99);
			if (roll < insert_pct)
				op = OP_INSERT;
			else if (roll < insert_pct + (100 - insert_pct) / 2)
				op = OP_LOOKUP;
			else if (roll < 97)
				op = OP_REMOVE;
			else
				op = OP_NONE;
			case ($urandom_range(3))
				0: value = $urandom;
				1: value = $urandom_range(15);
				2: value = (fill > 0) ? tracker.entries[$urandom_range(fill - 1)] : $urandom;
				default: value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			endcase
			if (fill > 0 && $urandom_range(9) < 8)
				pos = $urandom_range(fill - 1);
			else
				pos = $urandom_range(63);
			send_command(op, value, pos);
			// Pause now and then until the result side has caught up completely.
			if (i % 150 == 149)
				drain();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_NONE;
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty-table misses, the unknown command, extreme and equal
		// values, first/middle/last removes, and capacity below the count.
		send_command(OP_LOOKUP, 32'h0000_0000, 6'd0);
		send_command(OP_REMOVE, 32'h0000_0000, 6'd63);
		send_command(OP_NONE,   32'hFFFF_FFFF, 6'd63);
		send_command(OP_INSERT, 32'h0000_0000, 6'd0);
		send_command(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
		send_command(OP_INSERT, 32'h0000_0005, 6'd0);
		send_command(OP_INSERT, 32'h0000_0005, 6'd63);
		send_command(OP_INSERT, 32'h8000_0000, 6'd0);
		send_command(OP_INSERT, 32'h0000_0004, 6'd0);
		send_command(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
		send_command(OP_LOOKUP, 32'h0000_0000, 6'd5);
		send_command(OP_LOOKUP, 32'h0000_0000, 6'd6);
		send_command(OP_LOOKUP, 32'h0000_0000, 6'd63);
		send_command(OP_REMOVE, 32'h0000_0000, 6'd6);
		send_command(OP_REMOVE, 32'h0000_0000, 6'd2);
		send_command(OP_REMOVE, 32'h0000_0000, 6'd0);
		send_command(OP_REMOVE, 32'h0000_0000, 6'd3);
		send_command(OP_NONE,   32'h0000_0005, 6'd0);
		send_command(OP_LOOKUP, 32'h0000_0000, 6'd1);
		set_capacity(CW'(2));
		send_command(OP_INSERT, 32'h0000_0009, 6'd0);
		send_command(OP_REMOVE, 32'h0000_0000, 6'd0);
		send_command(OP_INSERT, 32'h0000_0009, 6'd0);
		send_command(OP_REMOVE, 32'h0000_0000, 6'd1);
		send_command(OP_INSERT, 32'h0000_0001, 6'd0);
		set_capacity(CW'(0));
		send_command(OP_INSERT, 32'h0000_0003, 6'd0);

		// Random: fill to DEPTH with the limit saturated, then shrink the
		// capacity under a full table and sweep the idling mixes.
		run_phase(CW'(127), 0,  0,  300, 70);
		run_phase(CW'(64),  45, 0,  300, 40);
		run_phase(CW'(10),  0,  45, 250, 20);
		run_phase(CW'(0),   10, 10, 100, 40);
		run_phase(CW'(1),   45, 0,  150, 50);
		run_phase(CW'(37),  0,  45, 200, 55);
		run_phase(CW'(65),  10, 10, 200, 65);

		drain();
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
